FILE: hdl/uds_transfer_session_checker_top_macros.svh
// Assertion macros for the transfer session checker.
// Used by the checker module bound to uds_transfer_session_checker_top.
`ifndef UDS_TRANSFER_SESSION_CHECKER_TOP_MACROS_SVH
`define UDS_TRANSFER_SESSION_CHECKER_TOP_MACROS_SVH

// Check a property at every clock edge once reset is released.
`define UTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define UTS_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/uts_pkg.sv
// Types and constants shared by the transfer session checker modules.
// No dependencies.
`default_nettype none

package uts_pkg;

    localparam int MAX_MESSAGE_BYTES = 4095;

    localparam logic [7:0]  POS_RSP_BYTE  = 8'h40;
    localparam logic [12:0] REQ_RSP_LEN   = 13'd5;
    localparam logic [11:0] MIN_REQ_LEN   = 12'd4;
    localparam logic [3:0]  MIN_ID_BYTES  = 4'd5;
    localparam logic [3:0]  MIN_SIZE_BYTES = 4'd1;
    localparam logic [3:0]  MAX_SIZE_BYTES = 4'd4;
    localparam logic [11:0] MIN_RSP_ROOM  = 12'd5;
    localparam logic [31:0] GRANT_SAT     = 32'hFFFF_FFFE;
    localparam logic [31:0] GRANT_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_REQ_DOWNLOAD = 2'd0,
        CMD_REQ_UPLOAD   = 2'd1,
        CMD_TRANSFER     = 2'd2,
        CMD_EXIT         = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_DOWN = 2'd1,
        MODE_UP   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_LENGTH     = 3'd1,
        ERR_RANGE      = 3'd2,
        ERR_CONDITIONS = 3'd3,
        ERR_SEQUENCE   = 3'd4,
        ERR_COUNTER    = 3'd5,
        ERR_CLIENT     = 3'd6
    } err_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_WRITE  = 3'd2,
        ACT_READ   = 3'd3,
        ACT_FINISH = 3'd4
    } action_t;

    typedef struct packed {
        cmd_t        command;
        logic [11:0] request_length;
        logic [7:0]  length_format;
        logic [31:0] memory_size;
        logic        object_found;
        logic [15:0] object_index;
        logic [31:0] client_block_length;
        logic [7:0]  sequence_number;
        logic [11:0] response_room;
        logic        client_accepts;
        logic [7:0]  client_reason;
    } req_t;

    typedef struct packed {
        logic        accepted;
        err_t        error_kind;
        logic [7:0]  client_code;
        logic [7:0]  first_response_byte;
        logic [31:0] granted_length;
        logic [12:0] response_length;
        action_t     client_action;
        logic [11:0] action_length;
        logic [15:0] action_object;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hdl/uts_in_reg.sv
// Input register of the transfer session checker.
// Depends on uts_pkg.
`default_nettype none

module uts_in_reg
    import uts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    input  wire logic advance,
    output logic      item_valid,
    output req_t      item
);

    logic item_valid_reg;
    logic item_valid_next;
    req_t item_reg;
    logic load;

    // hold while full and the item cannot move on
    assign req_stall = item_valid_reg && !advance;
    assign load      = req_valid && !req_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (load)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= req;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: hdl/uts_session.sv
// Session state and request checks of the transfer session checker.
// Depends on uts_pkg.
`default_nettype none

module uts_session
    import uts_pkg::*;
#(
    parameter int MAX_MSG_BYTES = MAX_MESSAGE_BYTES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t item,
    input  wire logic advance,
    output rsp_t      result
);

    mode_t       mode_reg,   mode_next;
    logic [7:0]  last_reg,   last_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] block_reg,  block_next;
    logic [15:0] object_reg, object_next;

    logic [11:0] room_lim;
    logic [11:0] room_eff;
    logic [11:0] room_m1;
    logic [3:0]  id_bytes;
    logic [3:0]  size_bytes;
    logic [11:0] fmt_len;
    logic [31:0] grant;
    logic [11:0] data_len;
    logic [11:0] min_len;
    logic [7:0]  seq_prev;
    logic        counter_ok;
    logic [31:0] up_raw;
    logic [11:0] up_len;
    action_t     xfer_act;
    logic [11:0] xfer_len;

    assign room_lim = (32'(item.response_room) > 32'(MAX_MSG_BYTES)) ?
                      12'(MAX_MSG_BYTES) : item.response_room;
    assign room_eff = (room_lim == 12'd0) ? 12'd1 : room_lim;
    assign room_m1  = room_eff - 12'd1;

    assign id_bytes   = item.length_format[3:0];
    assign size_bytes = item.length_format[7:4];
    assign fmt_len    = {8'd0, id_bytes} + {8'd0, size_bytes} + 12'd2;
    assign grant      = (item.client_block_length >= GRANT_SAT) ? GRANT_MAX :
                        item.client_block_length + 32'd2;

    assign min_len    = (mode_reg == MODE_DOWN) ? 12'd2 : 12'd1;
    assign data_len   = item.request_length - 12'd1;
    assign seq_prev   = item.sequence_number - 8'd1;
    assign counter_ok = (last_reg == item.sequence_number) || (last_reg == seq_prev);

    // upload length: smallest of block size, remaining bytes and response room less one
    assign up_raw   = (block_reg < remain_reg) ? block_reg : remain_reg;
    assign up_len   = ({20'd0, room_m1} < up_raw) ? room_m1 : up_raw[11:0];
    assign xfer_act = (mode_reg == MODE_DOWN) ? ACT_WRITE : ACT_READ;
    assign xfer_len = (mode_reg == MODE_DOWN) ? data_len : up_len;

    always_comb
    begin
        result      = '0;
        mode_next   = mode_reg;
        last_next   = last_reg;
        remain_next = remain_reg;
        block_next  = block_reg;
        object_next = object_reg;
        unique case (item.command)
            CMD_REQ_DOWNLOAD, CMD_REQ_UPLOAD:
            begin
                priority if (item.request_length < MIN_REQ_LEN)
                begin
                    result.error_kind = ERR_LENGTH;
                end
                else if (id_bytes < MIN_ID_BYTES || size_bytes < MIN_SIZE_BYTES ||
                         size_bytes > MAX_SIZE_BYTES)
                begin
                    result.error_kind = ERR_RANGE;
                end
                else if (item.request_length != fmt_len)
                begin
                    result.error_kind = ERR_LENGTH;
                end
                else if (mode_reg != MODE_NONE || room_eff < MIN_RSP_ROOM)
                begin
                    result.error_kind = ERR_CONDITIONS;
                end
                else if (!item.object_found)
                begin
                    result.error_kind = ERR_RANGE;
                end
                else if (!item.client_accepts)
                begin
                    result.error_kind    = ERR_CLIENT;
                    result.client_code   = item.client_reason;
                    result.client_action = ACT_START;
                    result.action_object = item.object_index;
                end
                else
                begin
                    result.accepted            = 1'b1;
                    result.first_response_byte = POS_RSP_BYTE;
                    result.granted_length      = grant;
                    result.response_length     = REQ_RSP_LEN;
                    result.client_action       = ACT_START;
                    result.action_object       = item.object_index;
                    mode_next   = (item.command == CMD_REQ_DOWNLOAD) ? MODE_DOWN : MODE_UP;
                    last_next   = 8'd0;
                    remain_next = item.memory_size;
                    block_next  = grant - 32'd2;
                    object_next = item.object_index;
                end
            end
            CMD_TRANSFER:
            begin
                priority if (item.request_length < min_len)
                begin
                    result.error_kind = ERR_LENGTH;
                end
                else if (mode_reg != MODE_DOWN && mode_reg != MODE_UP)
                begin
                    result.error_kind = ERR_SEQUENCE;
                end
                else if (!counter_ok)
                begin
                    result.error_kind = ERR_COUNTER;
                end
                else if (block_reg < {20'd0, data_len})
                begin
                    result.error_kind = ERR_LENGTH;
                end
                else if (mode_reg == MODE_UP && up_raw == 32'd0)
                begin
                    result.error_kind = ERR_SEQUENCE;
                end
                else if (!item.client_accepts)
                begin
                    result.error_kind    = ERR_CLIENT;
                    result.client_code   = item.client_reason;
                    result.client_action = xfer_act;
                    result.action_length = xfer_len;
                    result.action_object = object_reg;
                end
                else
                begin
                    result.accepted            = 1'b1;
                    result.first_response_byte = item.sequence_number;
                    result.client_action       = xfer_act;
                    result.action_length       = xfer_len;
                    result.action_object       = object_reg;
                    if (mode_reg == MODE_UP)
                    begin
                        result.response_length = {1'b0, up_len} + 13'd1;
                        // drop a repeated block from the byte count
                        if (last_reg != item.sequence_number)
                        begin
                            remain_next = remain_reg - {20'd0, up_len};
                        end
                    end
                    else
                    begin
                        result.response_length = 13'd1;
                    end
                    last_next = item.sequence_number;
                end
            end
            CMD_EXIT:
            begin
                priority if (mode_reg == MODE_NONE)
                begin
                    result.error_kind = ERR_SEQUENCE;
                end
                else if (item.request_length != 12'd0)
                begin
                    result.error_kind = ERR_RANGE;
                end
                else
                begin
                    result.accepted      = 1'b1;
                    result.client_action = ACT_FINISH;
                    result.action_object = object_reg;
                    mode_next            = MODE_NONE;
                end
            end
            default:
            begin
                result.error_kind = ERR_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            last_reg   <= 8'd0;
            remain_reg <= 32'd0;
            block_reg  <= 32'd0;
            object_reg <= 16'd0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            last_reg   <= last_next;
            remain_reg <= remain_next;
            block_reg  <= block_next;
            object_reg <= object_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/uts_out_reg.sv
// Result register of the transfer session checker.
// Depends on uts_pkg.
`default_nettype none

module uts_out_reg
    import uts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire rsp_t result,
    output logic      room,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;

    // free when empty or when the held response leaves this cycle
    assign room = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: hdl/uds_transfer_session_checker_top.sv
// Top level of the diagnostic transfer session checker.
// Depends on uts_pkg, uts_in_reg, uts_session and uts_out_reg.
//
// Usage:
//   The req channel carries one diagnostic request per handshake (request
//   download, request upload, transfer data, transfer exit) together with
//   the external object lookup and client verdicts for it. The rsp channel
//   returns exactly one response per request, in order.
//   A request is taken at a rising edge with req_valid high and req_stall low.
//   It lands in the input register, is checked against the session state by
//   combinational logic and lands in the result register, from which it
//   shows on rsp once the result register has room for it.
//   Throughput is one request per cycle while rsp_stall is low; session state
//   updates as each request enters the result register, so the next sees it.
//   When rsp_stall is high the held response stays put; the input register
//   still takes one more request, and req_stall rises only when both
//   registers are full and the response is stalled.
//   Reset clears both valid flags and returns the session to no transfer
//   active, counter, byte counts, block size and object all zero.
`default_nettype none

module uds_transfer_session_checker_top
    import uts_pkg::*;
#(
    parameter int MAX_MSG_BYTES = MAX_MESSAGE_BYTES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic item_valid;
    req_t item;
    rsp_t result;
    logic out_room;
    logic advance;

    // advance the held request whenever the result register can take it
    assign advance = item_valid && out_room;

    uts_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    uts_session #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_session (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    uts_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .room      (out_room),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

FILE: hdl/uts_checker.sv
// Port-level assertions for the transfer session checker, bound to the top.
// Depends on uts_pkg and uds_transfer_session_checker_top_macros.svh.
`default_nettype none
`include "uds_transfer_session_checker_top_macros.svh"

module uts_checker
    import uts_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // the flag is cleared by the reset edge itself, so check it at the next clock edge
    `UTS_ASSERT_ANY(a_reset_empty, !rst_n |=> !rsp_valid, "response valid after a reset edge")

    `UTS_ASSERT(a_hold_stalled, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")

    `UTS_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable(req), "stalled request changed")

    `UTS_ASSERT(a_no_backpressure, !rsp_stall |-> !req_stall, "request stalled while response side is free")

    `UTS_ASSERT(a_negative_clean, rsp_valid && !rsp.accepted |-> rsp.granted_length == 32'd0 && rsp.response_length == 13'd0 && rsp.error_kind != ERR_NONE, "negative response carries positive data")

endmodule

bind uds_transfer_session_checker_top uts_checker u_checker (.*);

`default_nettype wire
